FILE: rtl/lbm_pkg.sv
package lbm_pkg;

  localparam int VW   = 16;
  localparam int FB   = 14;
  localparam int NDIR = 9;

  // Moment and divider widths
  localparam int RW   = VW + 4;
  localparam int MW   = VW + 3;
  localparam int MAGW = MW - 1;
  localparam int AW   = MAGW + FB;
  localparam int DW   = RW - 1;
  localparam int QW   = VW;
  localparam int DBPS = 2;
  localparam int DIV_STAGES = (QW + DBPS - 1) / DBPS;
  localparam int QT   = DIV_STAGES * DBPS;

  // Equilibrium and relaxation widths
  localparam int DENW = VW + 2;
  localparam int ITW  = VW - 1;
  localparam int WRW  = RW;
  localparam int CUW  = VW + 1;
  localparam int SQW  = 2 * CUW;
  localparam int HW   = SQW + 4 - FB;
  localparam int PW0  = (HW > CUW + 2) ? HW : CUW + 2;
  localparam int PW1  = (PW0 > FB + 2) ? PW0 : FB + 2;
  localparam int PW   = PW1 + 2;
  localparam int FEW  = WRW + PW - FB;
  localparam int DFW  = ((FEW > VW) ? FEW : VW) + 1;
  localparam int RLW  = DFW + ITW + 1 - FB;
  localparam int GW   = ((RLW > VW) ? RLW : VW) + 1;

  localparam longint ONE  = 64'sd1 <<< FB;
  localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;

  // Lattice weights 4/9, 1/9, 1/36 rounded to nearest
  localparam logic [FB:0] WQ [3] = '{
    (FB+1)'((8 * ONE + 9) / 18),
    (FB+1)'((2 * ONE + 9) / 18),
    (FB+1)'((2 * ONE + 36) / 72)
  };

  localparam int CX   [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int CY   [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  // Which of ux, uy, ux+uy, ux-uy gives c.u, and its sign
  localparam int DSEL [NDIR] = '{0, 0, 1, 0, 1, 2, 3, 2, 3};
  localparam int DNEG [NDIR] = '{0, 0, 0, 1, 1, 0, 1, 1, 0};
  localparam int DHAS [NDIR] = '{0, 1, 1, 1, 1, 1, 1, 1, 1};
  localparam int WSEL [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

  localparam int CDW = 32;
  localparam int PAW = 2;
  localparam logic [PAW-1:0] ADDR_ITAU = PAW'(0);
  localparam logic [ITW-1:0] ITAU_RST  = ITW'(ONE);

  typedef logic [NDIR-1:0][VW-1:0] fvec_t;

  typedef struct packed {
    logic signed [VW-1:0] f_rest;
    logic signed [VW-1:0] f_east;
    logic signed [VW-1:0] f_north;
    logic signed [VW-1:0] f_west;
    logic signed [VW-1:0] f_south;
    logic signed [VW-1:0] f_northeast;
    logic signed [VW-1:0] f_northwest;
    logic signed [VW-1:0] f_southwest;
    logic signed [VW-1:0] f_southeast;
  } lbm_in_t;

  typedef struct packed {
    logic signed [VW-1:0] g_rest;
    logic signed [VW-1:0] g_east;
    logic signed [VW-1:0] g_north;
    logic signed [VW-1:0] g_west;
    logic signed [VW-1:0] g_south;
    logic signed [VW-1:0] g_northeast;
    logic signed [VW-1:0] g_northwest;
    logic signed [VW-1:0] g_southwest;
    logic signed [VW-1:0] g_southeast;
    logic [DENW-1:0]      density;
    logic signed [VW-1:0] velocity_x;
    logic signed [VW-1:0] velocity_y;
  } lbm_out_t;

  typedef struct packed {
    logic [DW-1:0]         dvs;
    logic [1:0]            neg;
    logic [1:0]            ovf;
    logic [1:0][QT-1:0]    a;
    logic [1:0][DW-1:0]    rem;
    logic [1:0][QT-1:0]    q;
  } div_t;

  typedef struct packed {
    fvec_t                f;
    logic [DENW-1:0]      dens;
    logic [2:0][WRW-1:0]  wr;
  } cr_t;

  typedef struct packed {
    logic [VW-1:0] x;
    logic [VW-1:0] y;
  } vel_t;

  // Restoring division, DBPS quotient bits for both axes
  function automatic div_t div_step(input div_t d);
    div_t          r;
    logic [DW:0]   t;
    r = d;
    for (int s = 0; s < DBPS; s++) begin
      for (int k = 0; k < 2; k++) begin
        t = {r.rem[k], r.a[k][QT-1]};
        r.a[k] = r.a[k] << 1;
        if (t >= {1'b0, r.dvs}) begin
          t = t - {1'b0, r.dvs};
          r.q[k] = {r.q[k][QT-2:0], 1'b1};
        end else begin
          r.q[k] = {r.q[k][QT-2:0], 1'b0};
        end
        r.rem[k] = t[DW-1:0];
      end
    end
    return r;
  endfunction

  // Apply sign to the quotient magnitude and saturate
  function automatic logic [VW-1:0] usat(input logic ng, input logic ov,
                                         input logic [QT-1:0] q);
    logic [QT:0] qe;
    logic [QT:0] lim;
    qe  = {1'b0, q};
    lim = (QT+1)'(VMAX);
    if (!ng) begin
      if (ov || qe > lim) return VW'(VMAX);
      return VW'(q);
    end
    if (ov || qe > lim + (QT+1)'(1)) return {1'b1, {(VW-1){1'b0}}};
    return VW'((QT+1)'(0) - qe);
  endfunction

  function automatic logic [VW-1:0] sat_v(input logic signed [GW-1:0] x);
    logic signed [GW-1:0] hi;
    logic signed [GW-1:0] lo;
    hi = GW'(VMAX);
    lo = ~hi;
    if (x > hi) return VW'(VMAX);
    if (x < lo) return {1'b1, {(VW-1){1'b0}}};
    return x[VW-1:0];
  endfunction

endpackage

FILE: rtl/lbm_in_if.sv
interface lbm_in_if;
  import lbm_pkg::*;
  logic    valid;
  logic    ready;
  lbm_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/lbm_out_if.sv
interface lbm_out_if;
  import lbm_pkg::*;
  logic     valid;
  logic     ready;
  lbm_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/lbm_d2q9_bgk_collision_unit.sv
// D2Q9 BGK collision, one lattice cell per beat.
// in_chan carries the nine distributions of a cell (signed Q2.14);
// out_chan returns the nine post-collision values, the density and the
// velocity. Both channels use valid/ready; a beat moves when both are high.
// inverse_tau sits at APB byte address 0 (unsigned Q1.14) and is read back
// there; write it only while no cell is in flight.
// Throughput: one cell per clock while the skid register is empty. A cell
// passes the moment stage, the divider setup, the velocity divider (eight
// stages, two quotient bits each) and seven multiply/add stages.
// Reset (rst_n low, synchronous) empties the pipeline and sets inverse_tau
// to 1.0. When the receiver stalls, the output register holds its beat and
// a skid register catches the one beat still leaving the pipeline; in_ready
// drops only while that skid register is full, and the whole pipeline
// freezes with it, so nothing is lost or repeated.
module lbm_d2q9_bgk_collision_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  lbm_in_if.sink                     in_chan,
  lbm_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbm_pkg::PAW-1:0]    paddr,
  input  logic [lbm_pkg::CDW-1:0]    pwdata,
  output logic [lbm_pkg::CDW-1:0]    prdata,
  output logic                       pready
);
  import lbm_pkg::*;

  logic en;
  logic [ITW-1:0] itau_r;

  // Stage 1: moments
  fvec_t                 in_f;
  logic signed [RW-1:0]  rho_sum;
  logic signed [MW-1:0]  mx_sum, my_sum;
  logic                  s1_v_r;
  fvec_t                 s1_f_r;
  logic signed [RW-1:0]  s1_rho_r;
  logic signed [MW-1:0]  s1_mx_r, s1_my_r;

  // Divider
  div_t                  dv0_nxt;
  cr_t                   cr0_nxt;
  logic [DIV_STAGES:0]   dv_v_r;
  div_t                  dv_r  [DIV_STAGES+1];
  cr_t                   dcr_r [DIV_STAGES+1];

  // Velocity and c.u terms
  vel_t                      u_vel_nxt;
  logic [3:0][CUW-1:0]       u_cu_nxt;
  logic                      u_v_r, q_v_r, h_v_r, p_v_r, e_v_r, d_v_r, r_v_r;
  cr_t                       u_cr_r, q_cr_r, h_cr_r, p_cr_r, e_cr_r, d_cr_r, r_cr_r;
  vel_t                      u_vel_r, q_vel_r, h_vel_r, p_vel_r, e_vel_r, d_vel_r, r_vel_r;
  logic [3:0][CUW-1:0]       u_cu_r, q_cu_r, h_cu_r;
  logic [3:0][SQW-1:0]       q_sq_nxt, q_sq_r;
  logic [3:0][HW-1:0]        h_h_nxt, h_h_r;
  logic [1:0][HW-1:0]        h_t3_nxt, h_t3_r;
  logic signed [PW-1:0]      p_poly_nxt [NDIR];
  logic signed [PW-1:0]      p_poly_r   [NDIR];
  logic signed [FEW-1:0]     e_feq_nxt  [NDIR];
  logic signed [FEW-1:0]     e_feq_r    [NDIR];
  logic signed [DFW-1:0]     d_diff_nxt [NDIR];
  logic signed [DFW-1:0]     d_diff_r   [NDIR];
  logic signed [RLW-1:0]     r_rel_nxt  [NDIR];
  logic signed [RLW-1:0]     r_rel_r    [NDIR];

  // Output side
  logic [NDIR-1:0][VW-1:0]   g;
  lbm_out_t                  ex_data;
  logic                      ex_v, out_free, out_ld, skid_ld, out_from_skid;
  logic                      out_v_nxt, skid_v_nxt;
  logic                      out_v_r, skid_v_r;
  lbm_out_t                  out_r, skid_r;

  assign en            = !skid_v_r;
  assign in_chan.ready = en;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ITAU) ? CDW'(itau_r) : '0;

  assign in_f = {in_chan.data.f_southeast, in_chan.data.f_southwest,
                 in_chan.data.f_northwest, in_chan.data.f_northeast,
                 in_chan.data.f_south, in_chan.data.f_west,
                 in_chan.data.f_north, in_chan.data.f_east,
                 in_chan.data.f_rest};

  always_comb begin
    logic signed [RW-1:0] fe;
    logic signed [MW-1:0] fm;
    rho_sum = '0;
    mx_sum  = '0;
    my_sum  = '0;
    for (int i = 0; i < NDIR; i++) begin
      fe = RW'($signed(in_f[i]));
      fm = MW'($signed(in_f[i]));
      rho_sum = rho_sum + fe;
      if (CX[i] > 0) mx_sum = mx_sum + fm;
      else if (CX[i] < 0) mx_sum = mx_sum - fm;
      if (CY[i] > 0) my_sum = my_sum + fm;
      else if (CY[i] < 0) my_sum = my_sum - fm;
    end
  end

  // Divider setup, weighted density and clamped density
  always_comb begin
    logic                      pos;
    logic signed [MW-1:0]      m;
    logic                      ng;
    logic [MAGW-1:0]           mag;
    logic [AW-1:0]             quo;
    logic signed [FB+RW+1:0]   wp;
    pos = s1_rho_r > 0;
    dv0_nxt = '0;
    dv0_nxt.dvs = pos ? s1_rho_r[DW-1:0] : DW'(1);
    for (int k = 0; k < 2; k++) begin
      m   = (k == 0) ? s1_mx_r : s1_my_r;
      ng  = m < 0;
      mag = pos ? MAGW'(ng ? -m : m) : '0;
      quo = {mag, {FB{1'b0}}};
      dv0_nxt.neg[k] = ng && pos;
      dv0_nxt.ovf[k] = AW'(quo >> QW) >= AW'(dv0_nxt.dvs);
      dv0_nxt.rem[k] = DW'(quo >> QT);
      dv0_nxt.a[k]   = quo[QT-1:0];
    end
    cr0_nxt.f = s1_f_r;
    for (int k = 0; k < 3; k++) begin
      wp = $signed({1'b0, WQ[k]}) * s1_rho_r;
      cr0_nxt.wr[k] = WRW'(wp >>> FB);
    end
    if (s1_rho_r < 0) cr0_nxt.dens = '0;
    else if (s1_rho_r[RW-1:DENW] != '0) cr0_nxt.dens = '1;
    else cr0_nxt.dens = s1_rho_r[DENW-1:0];
  end

  // Velocity from the quotients, then the four signed c.u values
  always_comb begin
    u_vel_nxt.x = usat(dv_r[DIV_STAGES].neg[0], dv_r[DIV_STAGES].ovf[0],
                       dv_r[DIV_STAGES].q[0]);
    u_vel_nxt.y = usat(dv_r[DIV_STAGES].neg[1], dv_r[DIV_STAGES].ovf[1],
                       dv_r[DIV_STAGES].q[1]);
    u_cu_nxt[0] = CUW'($signed(u_vel_nxt.x));
    u_cu_nxt[1] = CUW'($signed(u_vel_nxt.y));
    u_cu_nxt[2] = CUW'($signed(u_vel_nxt.x)) + CUW'($signed(u_vel_nxt.y));
    u_cu_nxt[3] = CUW'($signed(u_vel_nxt.x)) - CUW'($signed(u_vel_nxt.y));
  end

  always_comb begin
    logic signed [SQW-1:0] sq;
    for (int k = 0; k < 4; k++) begin
      sq = $signed(u_cu_r[k]) * $signed(u_cu_r[k]);
      q_sq_nxt[k] = sq;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      h_h_nxt[k] = HW'(((SQW+4)'(q_sq_r[k]) * 9) >> (FB + 1));
    end
    for (int k = 0; k < 2; k++) begin
      h_t3_nxt[k] = HW'(((SQW+4)'(q_sq_r[k]) * 3) >> (FB + 1));
    end
  end

  // poly = 1 + 3cu + 4.5cu^2 - 1.5u.u
  always_comb begin
    logic signed [PW-1:0] cui;
    logic signed [PW-1:0] hi;
    for (int i = 0; i < NDIR; i++) begin
      cui = '0;
      hi  = '0;
      if (DHAS[i] != 0) begin
        cui = PW'($signed(h_cu_r[DSEL[i]]));
        if (DNEG[i] != 0) cui = -cui;
        hi = $signed(PW'(h_h_r[DSEL[i]]));
      end
      p_poly_nxt[i] = PW'(ONE) + (cui <<< 1) + cui + hi
                      - $signed(PW'(h_t3_r[0])) - $signed(PW'(h_t3_r[1]));
    end
  end

  always_comb begin
    logic signed [WRW+PW-1:0] pr;
    for (int i = 0; i < NDIR; i++) begin
      pr = $signed(p_cr_r.wr[WSEL[i]]) * p_poly_r[i];
      e_feq_nxt[i] = FEW'(pr >>> FB);
    end
  end

  always_comb begin
    for (int i = 0; i < NDIR; i++) begin
      d_diff_nxt[i] = DFW'(e_feq_r[i]) - DFW'($signed(e_cr_r.f[i]));
    end
  end

  always_comb begin
    logic signed [DFW+ITW:0] rp;
    for (int i = 0; i < NDIR; i++) begin
      rp = d_diff_r[i] * $signed({1'b0, itau_r});
      r_rel_nxt[i] = RLW'(rp >>> FB);
    end
  end

  always_comb begin
    for (int i = 0; i < NDIR; i++) begin
      g[i] = sat_v(GW'(r_rel_r[i]) + GW'($signed(r_cr_r.f[i])));
    end
    ex_data.g_rest      = g[0];
    ex_data.g_east      = g[1];
    ex_data.g_north     = g[2];
    ex_data.g_west      = g[3];
    ex_data.g_south     = g[4];
    ex_data.g_northeast = g[5];
    ex_data.g_northwest = g[6];
    ex_data.g_southwest = g[7];
    ex_data.g_southeast = g[8];
    ex_data.density     = r_cr_r.dens;
    ex_data.velocity_x  = r_vel_r.x;
    ex_data.velocity_y  = r_vel_r.y;
  end

  // Output register with skid: drain skid first, park the leaving beat if stalled
  always_comb begin
    ex_v          = en && r_v_r;
    out_free      = !out_v_r || out_chan.ready;
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    out_ld        = 1'b0;
    skid_ld       = 1'b0;
    out_from_skid = 1'b0;
    if (out_free) begin
      if (skid_v_r) begin
        out_v_nxt     = 1'b1;
        out_ld        = 1'b1;
        out_from_skid = 1'b1;
        skid_v_nxt    = 1'b0;
      end else begin
        out_v_nxt = ex_v;
        out_ld    = ex_v;
      end
    end else if (ex_v) begin
      skid_v_nxt = 1'b1;
      skid_ld    = 1'b1;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itau_r   <= ITAU_RST;
      s1_v_r   <= 1'b0;
      dv_v_r   <= '0;
      u_v_r    <= 1'b0;
      q_v_r    <= 1'b0;
      h_v_r    <= 1'b0;
      p_v_r    <= 1'b0;
      e_v_r    <= 1'b0;
      d_v_r    <= 1'b0;
      r_v_r    <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == ADDR_ITAU) begin
        itau_r <= pwdata[ITW-1:0];
      end
      if (en) begin
        s1_v_r <= in_chan.valid;
        dv_v_r <= {dv_v_r[DIV_STAGES-1:0], s1_v_r};
        u_v_r  <= dv_v_r[DIV_STAGES];
        q_v_r  <= u_v_r;
        h_v_r  <= q_v_r;
        p_v_r  <= h_v_r;
        e_v_r  <= p_v_r;
        d_v_r  <= e_v_r;
        r_v_r  <= d_v_r;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_f_r   <= in_f;
      s1_rho_r <= rho_sum;
      s1_mx_r  <= mx_sum;
      s1_my_r  <= my_sum;
      dv_r[0]  <= dv0_nxt;
      dcr_r[0] <= cr0_nxt;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_r[k+1]  <= div_step(dv_r[k]);
        dcr_r[k+1] <= dcr_r[k];
      end
      u_cr_r   <= dcr_r[DIV_STAGES];
      u_vel_r  <= u_vel_nxt;
      u_cu_r   <= u_cu_nxt;
      q_cr_r   <= u_cr_r;
      q_vel_r  <= u_vel_r;
      q_cu_r   <= u_cu_r;
      q_sq_r   <= q_sq_nxt;
      h_cr_r   <= q_cr_r;
      h_vel_r  <= q_vel_r;
      h_cu_r   <= q_cu_r;
      h_h_r    <= h_h_nxt;
      h_t3_r   <= h_t3_nxt;
      p_cr_r   <= h_cr_r;
      p_vel_r  <= h_vel_r;
      p_poly_r <= p_poly_nxt;
      e_cr_r   <= p_cr_r;
      e_vel_r  <= p_vel_r;
      e_feq_r  <= e_feq_nxt;
      d_cr_r   <= e_cr_r;
      d_vel_r  <= e_vel_r;
      d_diff_r <= d_diff_nxt;
      r_cr_r   <= d_cr_r;
      r_vel_r  <= d_vel_r;
      r_rel_r  <= r_rel_nxt;
    end
    if (out_ld) begin
      out_r <= out_from_skid ? skid_r : ex_data;
    end
    if (skid_ld) begin
      skid_r <= ex_data;
    end
  end

endmodule

FILE: rtl/lbm_coll_chk.sv
module lbm_coll_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input lbm_pkg::lbm_out_t        out_data,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [lbm_pkg::PAW-1:0]  paddr,
  input logic [lbm_pkg::CDW-1:0]  pwdata,
  input logic [lbm_pkg::CDW-1:0]  prdata
);
  import lbm_pkg::*;

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Input back-pressure only with a full output register
  a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Zero density forces zero velocity
  a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.density == '0 |->
      out_data.velocity_x == '0 && out_data.velocity_y == '0)
    else $error("nonzero velocity at zero density");

  // A register write reads back on the next cycle
  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr == ADDR_ITAU |=>
      paddr != ADDR_ITAU || prdata == CDW'($past(pwdata[ITW-1:0])))
    else $error("inverse_tau readback mismatch");

endmodule

bind lbm_d2q9_bgk_collision_unit lbm_coll_chk u_lbm_coll_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

FILE: sim/lbm_d2q9_bgk_collision_unit_test.sv
module lbm_d2q9_bgk_collision_unit_test;
  import lbm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [CDW-1:0] pwdata = '0;
  logic [CDW-1:0] prdata;
  logic pready;

  lbm_in_if  in_chan();
  lbm_out_if out_chan();

  lbm_d2q9_bgk_collision_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    lbm_in_t  stim;
    bit       typed;
    lbm_out_t want;
  } cell_row_t;

  localparam int WATCH_LIMIT = 5000;
  localparam int PIPE_LAT    = 30;
  localparam longint WGT [NDIR] = '{7282, 1820, 1820, 1820, 1820, 455, 455, 455, 455};
  localparam int DX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  logic [ITW-1:0] itau_cur;
  lbm_out_t       collided_q[$];
  int             errors = 0;
  int             cells_in = 0;
  int             cells_out = 0;
  int             idle_cycles = 0;
  int             tau_settings = 0;

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic lbm_out_t collide(input lbm_in_t c, input logic [ITW-1:0] itau);
    longint f [NDIR];
    longint g [NDIR];
    longint rho, mx, my, ux, uy, t3, cu, poly, wr, feq, dens;
    lbm_out_t r;
    f = '{longint'(c.f_rest), longint'(c.f_east), longint'(c.f_north),
          longint'(c.f_west), longint'(c.f_south), longint'(c.f_northeast),
          longint'(c.f_northwest), longint'(c.f_southwest), longint'(c.f_southeast)};
    rho = 0; mx = 0; my = 0; ux = 0; uy = 0;
    for (int i = 0; i < NDIR; i++) begin
      rho += f[i];
      mx += DX[i] * f[i];
      my += DY[i] * f[i];
    end
    if (rho > 0) begin
      ux = sat16((mx * 16384) / rho);
      uy = sat16((my * 16384) / rho);
    end
    t3 = ((3 * ux * ux) >>> 15) + ((3 * uy * uy) >>> 15);
    for (int i = 0; i < NDIR; i++) begin
      cu = DX[i] * ux + DY[i] * uy;
      poly = 16384 + 3 * cu + ((9 * cu * cu) >>> 15) - t3;
      wr = (WGT[i] * rho) >>> 14;
      feq = (wr * poly) >>> 14;
      g[i] = sat16(f[i] + (((feq - f[i]) * longint'(itau)) >>> 14));
    end
    dens = rho < 0 ? 0 : (rho > 262143 ? 262143 : rho);
    r.g_rest = VW'(g[0]); r.g_east = VW'(g[1]); r.g_north = VW'(g[2]);
    r.g_west = VW'(g[3]); r.g_south = VW'(g[4]); r.g_northeast = VW'(g[5]);
    r.g_northwest = VW'(g[6]); r.g_southwest = VW'(g[7]); r.g_southeast = VW'(g[8]);
    r.density = DENW'(dens);
    r.velocity_x = VW'(ux);
    r.velocity_y = VW'(uy);
    return r;
  endfunction

  function automatic lbm_in_t fill(input logic signed [VW-1:0] v);
    lbm_in_t c;
    c = '{v, v, v, v, v, v, v, v, v};
    return c;
  endfunction

  // Near-equilibrium cell: weights times a density from 0.5 to 1.5 plus jitter
  function automatic lbm_in_t near_eq_cell();
    logic [NDIR-1:0][VW-1:0] fv;
    longint base, v;
    base = $urandom_range(24576, 8192);
    for (int i = 0; i < NDIR; i++) begin
      v = (WGT[i] * base) >>> 14;
      v += $signed($urandom_range(1200, 0)) - 600;
      fv[NDIR-1-i] = VW'(v);
    end
    return lbm_in_t'(fv);
  endfunction

  function automatic lbm_in_t noise_cell();
    logic [NDIR-1:0][VW-1:0] fv;
    for (int i = 0; i < NDIR; i++) begin
      fv[i] = VW'($urandom);
      if ($urandom_range(3, 0) == 0) fv[i] = {VW{fv[i][0]}} ^ VW'($urandom_range(3, 0));
    end
    return lbm_in_t'(fv);
  endfunction

  task automatic check_field(input string nm, input longint want, input longint got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, nm, want, got);
      errors++;
    end
  endtask

  task automatic check_cell(input lbm_out_t w, input lbm_out_t a);
    check_field("g_rest", w.g_rest, a.g_rest);
    check_field("g_east", w.g_east, a.g_east);
    check_field("g_north", w.g_north, a.g_north);
    check_field("g_west", w.g_west, a.g_west);
    check_field("g_south", w.g_south, a.g_south);
    check_field("g_northeast", w.g_northeast, a.g_northeast);
    check_field("g_northwest", w.g_northwest, a.g_northwest);
    check_field("g_southwest", w.g_southwest, a.g_southwest);
    check_field("g_southeast", w.g_southeast, a.g_southeast);
    check_field("density", w.density, a.density);
    check_field("velocity_x", w.velocity_x, a.velocity_x);
    check_field("velocity_y", w.velocity_y, a.velocity_y);
  endtask

  // Receiver: a randomly chosen stall pattern holds for each stretch, then is redrawn
  int stall_mode = 0;
  int stretch = 0;
  always @(posedge clk) begin
    if (stretch == 0) begin
      stall_mode <= $urandom_range(2, 0);
      stretch <= 64;
    end else begin
      stretch <= stretch - 1;
    end
    case (stall_mode)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= $urandom_range(1, 0);
      default: out_chan.ready <= ($urandom_range(3, 0) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      cells_out++;
      if (collided_q.size() == 0) begin
        $display("%0t unexpected beat density %0d", $time, out_chan.data.density);
        errors++;
      end else begin
        check_cell(collided_q.pop_front(), out_chan.data);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, WATCH_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_tau(input logic [ITW-1:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_ITAU; pwdata <= CDW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ITW-1:0] != v) begin
      $display("%0t mismatch inverse_tau readback expected %0d actual %0d",
               $time, v, prdata[ITW-1:0]);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    itau_cur = v;
    tau_settings++;
  endtask

  task automatic drain();
    while (collided_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // Send one beat; hold valid until accepted
  task automatic send_cell(input lbm_in_t c, input bit typed, input lbm_out_t want);
    in_chan.valid <= 1'b1;
    in_chan.data <= c;
    do @(posedge clk); while (!in_chan.ready);
    collided_q.push_back(typed ? want : collide(c, itau_cur));
    cells_in++;
  endtask

  cell_row_t rows[$];

  initial begin
    cell_row_t r;
    lbm_in_t c;
    int burst;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    itau_cur = ITAU_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    r.typed = 1'b1;
    r.stim = fill(16'sd0); r.want = '0; rows.push_back(r);
    r.stim = fill(16'sh8000);
    r.want = '{16'sh8000, -16'sd32760, -16'sd32760, -16'sd32760, -16'sd32760,
               -16'sd8190, -16'sd8190, -16'sd8190, -16'sd8190, 18'd0, 16'sd0, 16'sd0};
    rows.push_back(r);
    r.stim = fill(16'sd32767);
    r.want = '{16'sd32767, 16'sd32759, 16'sd32759, 16'sd32759, 16'sd32759,
               16'sd8189, 16'sd8189, 16'sd8189, 16'sd8189, 18'd262143, 16'sd0, 16'sd0};
    rows.push_back(r);
    r.typed = 1'b0;
    for (int i = 0; i < NDIR; i++) begin
      logic [NDIR-1:0][VW-1:0] fv;
      fv = '0;
      fv[NDIR-1-i] = 16'h7fff;
      r.stim = lbm_in_t'(fv); rows.push_back(r);
    end
    // velocity saturating high and low, density barely positive
    c = '0; c.f_rest = 1; c.f_east = 32767; c.f_west = -32767;
    c.f_north = 32767; c.f_south = -32767;
    r.stim = c; rows.push_back(r);
    c.f_east = -32767; c.f_west = 32767; c.f_north = -32767; c.f_south = 32767;
    r.stim = c; rows.push_back(r);
    // nonzero momentum with negative density, then with a density of one
    c = '0; c.f_east = 16000; c.f_west = -20000; r.stim = c; rows.push_back(r);
    c = '0; c.f_northeast = 32767; c.f_southwest = -32768; c.f_rest = 2;
    r.stim = c; rows.push_back(r);
    for (int i = 0; i < 4; i++) begin
      r.stim = near_eq_cell(); rows.push_back(r);
    end

    foreach (rows[i]) send_cell(rows[i].stim, rows[i].typed, rows[i].want);
    in_chan.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      int n;
      case (ph)
        0: write_tau(ITW'(0));
        1: write_tau(ITW'(32767));
        2: write_tau(ITAU_RST);
        default: write_tau(ITW'($urandom_range(32767, 0)));
      endcase
      n = 0;
      while (n < 330) begin
        burst = $urandom_range(40, 1);
        for (int k = 0; k < burst && n < 330; k++) begin
          c = ($urandom_range(9, 0) < 7) ? near_eq_cell() : noise_cell();
          send_cell(c, 1'b0, '0);
          n++;
        end
        if ($urandom_range(2, 0) != 0) begin
          in_chan.valid <= 1'b0;
          repeat ($urandom_range(6, 1)) @(posedge clk);
        end
      end
      in_chan.valid <= 1'b0;
      drain();
    end

    $display("cells sent %0d, checked %0d, inverse_tau settings %0d",
             cells_in, cells_out, tau_settings);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("errors %0d", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
